// File: hw/rtl/i2ctb_pkg.sv
// Shared constants, codes and types of the I2C target bit engine.
package i2ctb_pkg;

  localparam int BUFFER_BYTES = 4;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int BC_W         = $clog2(BUFFER_BYTES + 1);
  localparam int BYTE_W       = 8;
  localparam int STEP_W       = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;
  localparam logic [2:0]        BYTE_MSB  = 3'd7;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RX_BIT,
    PH_RX_ACK_DRIVE,
    PH_RX_ACK_DONE,
    PH_TX_BIT,
    PH_TX_ACK_FREE,
    PH_TX_ACK_DONE,
    PH_FINISH
  } phase_t;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    op_t              op;
    logic             start;
    logic             scl_edge;
    logic             sda;
    logic [1:0]       idx;
    logic [BYTE_W-1:0] val;
  } item_t;

endpackage

// File: hw/rtl/i2ctb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: hw/rtl/i2ctb_front.sv
// Front end: accepts items, tracks the previous pin levels and classifies samples.
module i2ctb_front import i2ctb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic              in_scl_level,
  input  logic              in_sda_level,
  input  logic [1:0]        in_buf_index,
  input  logic [BYTE_W-1:0] in_buf_value,
  input  logic              q_full,
  output logic              push,
  output item_t             item
);

  logic prev_scl_r, prev_scl_nxt;
  logic prev_sda_r, prev_sda_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    item.op       = op_t'(in_op);
    item.start    = prev_scl_r & in_scl_level & prev_sda_r & ~in_sda_level;
    item.scl_edge = in_scl_level ^ prev_scl_r;
    item.sda      = in_sda_level;
    item.idx      = in_buf_index;
    item.val      = in_buf_value;
  end

  // Only pin samples move the remembered levels
  always_comb begin
    prev_scl_nxt = prev_scl_r;
    prev_sda_nxt = prev_sda_r;
    if (push && item.op == OP_SAMPLE) begin
      prev_scl_nxt = in_scl_level;
      prev_sda_nxt = in_sda_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_scl_r <= 1'b1;
      prev_sda_r <= 1'b1;
    end else begin
      prev_scl_r <= prev_scl_nxt;
      prev_sda_r <= prev_sda_nxt;
    end
  end

endmodule

// File: hw/rtl/i2ctb_queue.sv
// Short FIFO between the front end and the bit engine.
module i2ctb_queue import i2ctb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond its depth");
`endif

endmodule

// File: hw/rtl/i2ctb_back.sv
// Back end: bus phase sequencer, byte buffer and result register.
module i2ctb_back import i2ctb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_sda_pull_low,
  output logic              out_transfer_done,
  output logic              out_busy_res,
  output logic [2:0]        out_byte_position,
  output logic [BYTE_W-1:0] out_read_value
);

  phase_t            phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic              drive_r, drive_nxt;
  logic              done_r, done_nxt;
  logic [BYTE_W-1:0] cur_r, cur_nxt;
  logic              lsb0_r, lsb0_nxt;
  logic              pend_r, pend_nxt;

  logic              out_valid_r;
  logic              out_drive_r;
  logic              out_done_r;
  logic              out_busy_r;
  logic [2:0]        out_pos_r;
  logic              out_rd_r, out_rd_nxt;

  logic              advance;
  logic              launch;
  logic              bc_ok;
  logic              idx_ok;
  logic [2:0]        kidx;
  logic [BC_W-1:0]   bc_inc;
  logic [BYTE_W-1:0] cur_eff;
  logic [BYTE_W-1:0] cur_mod;

  logic              wr_en;
  logic [BUF_AW-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BUF_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign advance = !q_empty && (!out_valid_r || out_ready);
  assign q_pop   = advance;

  // cur_r mirrors buffer[bc]; after bc moves it is refilled from the RAM
  assign cur_eff = pend_r ? rd_data : cur_r;
  assign kidx    = step_r[STEP_W-1:1];
  assign bc_ok   = (bc_r < BC_W'(BUFFER_BYTES));
  assign idx_ok  = (BC_W'(q_item.idx) < BC_W'(BUFFER_BYTES));
  assign bc_inc  = BC_W'(bc_r + 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    bc_nxt    = bc_r;
    drive_nxt = drive_r;
    done_nxt  = done_r;
    cur_nxt   = cur_eff;
    cur_mod   = cur_eff;
    lsb0_nxt  = lsb0_r;
    pend_nxt  = pend_r;
    launch    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = bc_r[BUF_AW-1:0];
    wr_data   = cur_eff;
    if (advance) begin
      pend_nxt = 1'b0;
      case (q_item.op)
        OP_SAMPLE: begin
          if (phase_r == PH_IDLE) begin
            if (q_item.start) begin
              bc_nxt    = '0;
              step_nxt  = '0;
              phase_nxt = PH_RX_BIT;
              launch    = 1'b1;
            end
          end else if (q_item.scl_edge) begin
            case (phase_r)
              PH_RX_BIT: begin
                if (!step_r[0]) begin
                  if (kidx == '0) begin
                    drive_nxt = 1'b0;
                    cur_mod   = '0;
                    wr_en     = bc_ok;
                  end
                end else if (q_item.sda) begin
                  cur_mod[BYTE_MSB - kidx] = 1'b1;
                  wr_en = bc_ok;
                end
                wr_data  = cur_mod;
                cur_nxt  = cur_mod;
                step_nxt = STEP_W'(step_r + 1'b1);
                if (step_r == STEP_LAST) begin
                  phase_nxt = PH_RX_ACK_DRIVE;
                end
              end
              PH_RX_ACK_DRIVE: begin
                drive_nxt = 1'b1;
                phase_nxt = PH_RX_ACK_DONE;
              end
              PH_RX_ACK_DONE: begin
                bc_nxt   = bc_inc;
                step_nxt = '0;
                launch   = 1'b1;
                if (bc_inc >= BC_W'(BUFFER_BYTES)) begin
                  phase_nxt = PH_FINISH;
                end else if (lsb0_r) begin
                  phase_nxt = PH_TX_BIT;
                end else begin
                  phase_nxt = PH_RX_BIT;
                end
              end
              PH_TX_BIT: begin
                if (!step_r[0]) begin
                  drive_nxt = ~cur_eff[BYTE_MSB - kidx];
                end
                step_nxt = STEP_W'(step_r + 1'b1);
                if (step_r == STEP_LAST) begin
                  phase_nxt = PH_TX_ACK_FREE;
                end
              end
              PH_TX_ACK_FREE: begin
                drive_nxt = 1'b0;
                phase_nxt = PH_TX_ACK_DONE;
              end
              PH_TX_ACK_DONE: begin
                bc_nxt   = bc_inc;
                step_nxt = '0;
                launch   = 1'b1;
                phase_nxt = (bc_inc >= BC_W'(BUFFER_BYTES)) ? PH_FINISH : PH_TX_BIT;
              end
              default: begin
                drive_nxt = 1'b0;
                done_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        OP_WRITE: begin
          if (idx_ok) begin
            wr_en   = 1'b1;
            wr_addr = BUF_AW'(q_item.idx);
            wr_data = q_item.val;
            if (BC_W'(q_item.idx) == bc_r) begin
              cur_nxt = q_item.val;
            end
          end
        end
        OP_READ: begin
          // read data returns through the RAM output register
        end
        OP_CLEAR: begin
          done_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      if (launch) begin
        pend_nxt = 1'b1;
      end
      if (wr_en && wr_addr == '0) begin
        lsb0_nxt = wr_data[0];
      end
    end
  end

  assign rd_addr    = launch ? bc_nxt[BUF_AW-1:0] : BUF_AW'(q_item.idx);
  assign out_rd_nxt = (q_item.op == OP_READ) && idx_ok;

  i2ctb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (advance),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      bc_r        <= '0;
      drive_r     <= 1'b0;
      done_r      <= 1'b0;
      lsb0_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      bc_r    <= bc_nxt;
      drive_r <= drive_nxt;
      done_r  <= done_nxt;
      lsb0_r  <= lsb0_nxt;
      pend_r  <= pend_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (advance) begin
      out_drive_r <= drive_nxt;
      out_done_r  <= done_nxt;
      out_busy_r  <= (phase_nxt != PH_IDLE);
      out_pos_r   <= 3'(bc_nxt);
      out_rd_r    <= out_rd_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sda_pull_low  = out_drive_r;
  assign out_transfer_done = out_done_r;
  assign out_busy_res      = out_busy_r;
  assign out_byte_position = out_pos_r;
  assign out_read_value    = out_rd_r ? rd_data : '0;

`ifndef ASSERT_OFF
  a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= BC_W'(BUFFER_BYTES))
    else $error("byte counter beyond buffer size");

  a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RX_BIT || phase_r == PH_TX_BIT) |-> bc_ok)
    else $error("bit phase with byte counter out of range");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !drive_r)
    else $error("SDA held low while idle");

  a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(done_r) && done_r) |-> ($past(phase_r) == PH_FINISH))
    else $error("done flag set outside the finish phase");
`endif

endmodule

// File: hw/rtl/i2c_target_bit_engine.sv
// Top level of the I2C target bit engine: front end, queue and back end.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | input     | in_valid/in_ready   | op, scl_level, sda_level, buf_index,
//          |           |                     | buf_value
//  out_    | output    | out_valid/out_ready | sda_pull_low, transfer_done, busy_res,
//          |           |                     | byte_position, read_value
//
// One item per cycle is sustained while out_ready is high; each transfer yields exactly
// one result transfer. An item passes through a queue slot, then the result registers.
// The buffer byte used for transmit is kept in a mirror register and refilled
// from the buffer RAM's registered read data after the byte counter moves.
// Reset (rst_n low, synchronous) idles the bus phase, clears the done flag and
// byte counter, and treats both pins as released; buffer contents are not cleared.
// A stalled result holds the back end; the two-entry queue keeps in_ready high
// until it fills.
module i2c_target_bit_engine import i2ctb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic              in_scl_level,
  input  logic              in_sda_level,
  input  logic [1:0]        in_buf_index,
  input  logic [BYTE_W-1:0] in_buf_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_sda_pull_low,
  output logic              out_transfer_done,
  output logic              out_busy_res,
  output logic [2:0]        out_byte_position,
  output logic [BYTE_W-1:0] out_read_value
);

  logic  push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  item_t push_item;
  item_t head_item;

  // Classify each incoming transfer: start condition and SCL edge
  i2ctb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_scl_level (in_scl_level),
    .in_sda_level (in_sda_level),
    .in_buf_index (in_buf_index),
    .in_buf_value (in_buf_value),
    .q_full       (q_full),
    .push         (push),
    .item         (push_item)
  );

  // Decouple the front end from result back-pressure
  i2ctb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  // Advance the bus phase, access the buffer and register the result
  i2ctb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sda_pull_low  (out_sda_pull_low),
    .out_transfer_done (out_transfer_done),
    .out_busy_res      (out_busy_res),
    .out_byte_position (out_byte_position),
    .out_read_value    (out_read_value)
  );

endmodule
